>>> rtl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants for the RV32 subset execute unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int PC_W = 32;
  localparam logic [PC_W-1:0] PC_STEP = 32'd4;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_BNE  = 4'd2,
    OP_JAL  = 4'd3,
    OP_JALR = 4'd4,
    OP_ADDI = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_XOR  = 4'd8,
    OP_SLL  = 4'd9,
    OP_SRL  = 4'd10,
    OP_SRA  = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNDEF_TGT  = 2'd1,
    ERR_UNKNOWN_OP = 2'd2
  } err_t;

  // Control half of one executed instruction
  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic            reg_written;
    err_t            error_code;
  } exec_ctl_t;

endpackage

>>> rtl/rvx_ram.sv
// ----------------------------------------------------------------------------
// rvx_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/rvx_alu.sv
// ----------------------------------------------------------------------------
// rvx_alu
// Combinational execute logic: ALU result, next pc and write decision.
// ----------------------------------------------------------------------------
module rvx_alu
  import rvx_pkg::*;
#(
  parameter int REG_COUNT  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic [3:0]            mode,
  input  logic [4:0]            dest_reg,
  input  logic [DATA_WIDTH-1:0] op_a,
  input  logic [DATA_WIDTH-1:0] op_b,
  input  logic signed [11:0]    immediate,
  input  logic [29:0]           target_index,
  input  logic                  target_known,
  input  logic [PC_W-1:0]       pc,
  output exec_ctl_t             ctl,
  output logic [DATA_WIDTH-1:0] wr_val
);

  logic signed [63:0]    imm_ext;
  logic signed [63:0]    a_ext;
  logic [63:0]           jalr_sum;
  logic [PC_W-1:0]       link;
  logic [PC_W-1:0]       target;
  logic [4:0]            shamt;
  logic [DATA_WIDTH-1:0] imm_d;
  logic                  wr;

  assign imm_ext  = 64'(immediate);
  assign a_ext    = 64'($signed(op_a));
  assign jalr_sum = a_ext + imm_ext;
  assign link     = pc + PC_STEP;
  assign target   = {target_index, 2'b00};
  assign shamt    = immediate[4:0];
  assign imm_d    = imm_ext[DATA_WIDTH-1:0];

  always_comb begin
    ctl.next_pc    = link;
    ctl.error_code = ERR_NONE;
    wr             = 1'b1;
    wr_val         = '0;
    unique case (mode)
      OP_ADD:  wr_val = op_a + op_b;
      OP_SUB:  wr_val = op_a - op_b;
      OP_BNE: begin
        wr = 1'b0;
        if (op_a != op_b) begin
          if (target_known) begin
            ctl.next_pc = target;
          end else begin
            ctl.next_pc    = pc;
            ctl.error_code = ERR_UNDEF_TGT;
          end
        end
      end
      OP_JAL: begin
        wr_val = DATA_WIDTH'(link);
        if (target_known) begin
          ctl.next_pc = target;
        end else begin
          ctl.next_pc    = pc;
          ctl.error_code = ERR_UNDEF_TGT;
        end
      end
      OP_JALR: begin
        wr_val      = DATA_WIDTH'(link);
        ctl.next_pc = {jalr_sum[PC_W-1:1], 1'b0};
      end
      OP_ADDI: wr_val = op_a + imm_d;
      OP_AND:  wr_val = op_a & op_b;
      OP_OR:   wr_val = op_a | op_b;
      OP_XOR:  wr_val = op_a ^ op_b;
      OP_SLL:  wr_val = op_a << shamt;
      OP_SRL:  wr_val = op_a >> shamt;
      OP_SRA:  wr_val = DATA_WIDTH'($signed(op_a) >>> shamt);
      default: begin
        wr             = 1'b0;
        ctl.next_pc    = pc;
        ctl.error_code = ERR_UNKNOWN_OP;
      end
    endcase
    // drop writes to x0 and to registers that do not exist
    ctl.reg_written = wr && (dest_reg != '0) && (32'(dest_reg) < REG_COUNT);
  end

endmodule

>>> rtl/rv32_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32_subset_execute_unit
// Executes one decoded RV32I-subset instruction per beat against a register
// file and a program counter.
// ----------------------------------------------------------------------------
// Pipeline: register file read into the execute stage, then execute into the
//   result register; both hold while a result waits for out_ready.
// Throughput: 1 instruction per cycle unless the result side stalls; a write is forwarded to the next one.
// Reset: pc and all registers read as zero; register valid bits are cleared
//   at once, so no clearing pass is needed.
module rv32_subset_execute_unit
  import rvx_pkg::*;
#(
  parameter int REG_COUNT  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         mode,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         src_reg_a,
  input  logic [4:0]         src_reg_b,
  input  logic signed [11:0] immediate,
  input  logic [29:0]        target_index,
  input  logic               target_known,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        next_pc,
  output logic               reg_written,
  output logic [4:0]         write_index,
  output logic signed [31:0] write_value,
  output logic [1:0]         error_code
);

  localparam int ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic                  in_fire;
  logic                  ex_adv;

  // execute stage
  logic                  ex_valid;
  logic [3:0]            ex_mode;
  logic [4:0]            ex_rd;
  logic signed [11:0]    ex_imm;
  logic [29:0]           ex_tidx;
  logic                  ex_tknown;
  logic                  ex_use_a;
  logic                  ex_use_b;
  logic                  ex_fwd_a;
  logic                  ex_fwd_b;
  logic [DATA_WIDTH-1:0] ex_fwd_val;

  logic [PC_W-1:0]       pc;
  logic [REG_COUNT-1:0]  vld;

  logic [DATA_WIDTH-1:0] rdata_a;
  logic [DATA_WIDTH-1:0] rdata_b;
  logic [DATA_WIDTH-1:0] op_a;
  logic [DATA_WIDTH-1:0] op_b;
  exec_ctl_t             ctl;
  logic [DATA_WIDTH-1:0] wr_val;
  logic                  wr_en;
  logic                  use_a;
  logic                  use_b;

  assign ex_adv   = ex_valid && (!out_valid || out_ready);
  assign in_ready = !ex_valid || ex_adv;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = ex_adv && ctl.reg_written;

  // x0 and missing registers read as zero, as do entries never written
  assign use_a = (src_reg_a != '0) && (32'(src_reg_a) < REG_COUNT) && vld[ADDR_W'(src_reg_a)];
  assign use_b = (src_reg_b != '0) && (32'(src_reg_b) < REG_COUNT) && vld[ADDR_W'(src_reg_b)];

  rvx_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (ADDR_W'(ex_rd)),
    .wdata   (wr_val),
    .re      (in_fire),
    .raddr_a (ADDR_W'(src_reg_a)),
    .raddr_b (ADDR_W'(src_reg_b)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_fire) begin
      ex_valid <= 1'b1;
    end else if (ex_adv) begin
      ex_valid <= 1'b0;
    end
  end

  // capture operands; bypass the write retiring on the same edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_mode    <= mode;
      ex_rd      <= dest_reg;
      ex_imm     <= immediate;
      ex_tidx    <= target_index;
      ex_tknown  <= target_known;
      ex_use_a   <= use_a;
      ex_use_b   <= use_b;
      ex_fwd_a   <= wr_en && (ex_rd == src_reg_a);
      ex_fwd_b   <= wr_en && (ex_rd == src_reg_b);
      ex_fwd_val <= wr_val;
    end
  end

  assign op_a = ex_fwd_a ? ex_fwd_val : (ex_use_a ? rdata_a : '0);
  assign op_b = ex_fwd_b ? ex_fwd_val : (ex_use_b ? rdata_b : '0);

  rvx_alu #(
    .REG_COUNT  (REG_COUNT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .mode         (ex_mode),
    .dest_reg     (ex_rd),
    .op_a         (op_a),
    .op_b         (op_b),
    .immediate    (ex_imm),
    .target_index (ex_tidx),
    .target_known (ex_tknown),
    .pc           (pc),
    .ctl          (ctl),
    .wr_val       (wr_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      vld <= '0;
    end else if (ex_adv) begin
      pc <= ctl.next_pc;
      if (ctl.reg_written) begin
        vld[ADDR_W'(ex_rd)] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      next_pc     <= ctl.next_pc;
      reg_written <= ctl.reg_written;
      write_index <= ctl.reg_written ? ex_rd : '0;
      write_value <= ctl.reg_written ? 32'($signed(wr_val)) : '0;
      error_code  <= ctl.error_code;
    end
  end

endmodule

>>> tb/sv/rv32_exec_checker.sv
// ----------------------------------------------------------------------------
// rv32_exec_checker
// Watches both channels of the RV32 subset execute unit. It keeps its own copy
// of the register file and the pc, predicts the retirement record of every
// accepted instruction, and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module rv32_exec_checker
  import rvx_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         mode,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         src_reg_a,
  input  logic [4:0]         src_reg_b,
  input  logic signed [11:0] immediate,
  input  logic [29:0]        target_index,
  input  logic               target_known,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        next_pc,
  input  logic               reg_written,
  input  logic [4:0]         write_index,
  input  logic signed [31:0] write_value,
  input  logic [1:0]         error_code,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_REPORTS = 10;
  localparam logic [4:0] X0          = 5'd0;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    err_t        error_code;
  } retire_t;

  logic [31:0] gpr [32];
  logic [31:0] pc_model;
  retire_t     retire_q [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [31:0] read_gpr(logic [4:0] idx);
    return (idx == X0) ? 32'd0 : gpr[idx];
  endfunction

  // Execute one instruction on the model state and return its retirement record
  function automatic retire_t execute_instr(
    logic [3:0] op, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
    logic [11:0] imm, logic [29:0] tidx, logic known);
    logic [31:0] a, b, imm32, target, link, npc, val;
    logic [4:0]  sh;
    logic        wr;
    err_t        err;
    retire_t     r;
    a      = read_gpr(ra);
    b      = read_gpr(rb);
    imm32  = {{20{imm[11]}}, imm};
    target = {tidx, 2'b00};
    sh     = imm[4:0];
    npc    = pc_model + PC_STEP;
    link   = npc;
    wr     = 1'b1;
    val    = '0;
    err    = ERR_NONE;
    case (op)
      OP_ADD:  val = a + b;
      OP_SUB:  val = a - b;
      OP_BNE: begin
        wr = 1'b0;
        if (a != b) begin
          if (known) begin
            npc = target;
          end else begin
            npc = pc_model;
            err = ERR_UNDEF_TGT;
          end
        end
      end
      OP_JAL: begin
        // link is written even when the target is missing
        val = link;
        if (known) begin
          npc = target;
        end else begin
          npc = pc_model;
          err = ERR_UNDEF_TGT;
        end
      end
      OP_JALR: begin
        val = link;
        npc = (a + imm32) & ~32'd1;
      end
      OP_ADDI: val = a + imm32;
      OP_AND:  val = a & b;
      OP_OR:   val = a | b;
      OP_XOR:  val = a ^ b;
      OP_SLL:  val = a << sh;
      OP_SRL:  val = a >> sh;
      OP_SRA:  val = $signed(a) >>> sh;
      default: begin
        wr  = 1'b0;
        npc = pc_model;
        err = ERR_UNKNOWN_OP;
      end
    endcase
    // drop writes to x0
    if (wr && rd == X0)
      wr = 1'b0;
    if (wr)
      gpr[rd] = val;
    pc_model      = npc;
    r.next_pc     = npc;
    r.reg_written = wr;
    r.write_index = wr ? rd : X0;
    r.write_value = wr ? val : 32'd0;
    r.error_code  = err;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    retire_t want;
    if (rst) begin
      foreach (gpr[i])
        gpr[i] = '0;
      pc_model = '0;
      retire_q.delete();
    end else begin
      // pop before push so a beat can never match its own instruction
      if (out_valid && out_ready) begin
        if (retire_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] result beat with nothing expected: pc=%h wr=%0d idx=%0d val=%h err=%0d",
                     $realtime, next_pc, reg_written, write_index, write_value, error_code);
        end else begin
          want = retire_q.pop_front();
          if (want.next_pc !== next_pc || want.reg_written !== reg_written ||
              want.write_index !== write_index || want.write_value !== write_value ||
              want.error_code !== error_code) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected pc=%h wr=%0d idx=%0d val=%h err=%0d",
                       want.next_pc, want.reg_written, want.write_index,
                       want.write_value, want.error_code);
              $display("  actual   pc=%h wr=%0d idx=%0d val=%h err=%0d",
                       next_pc, reg_written, write_index, write_value, error_code);
            end
          end
        end
      end
      if (in_valid && in_ready)
        retire_q.push_back(execute_instr(mode, dest_reg, src_reg_a, src_reg_b,
                                         immediate, target_index, target_known));
    end
    outstanding <= retire_q.size();
  end

endmodule

>>> tb/sv/tb_rv32_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_rv32_subset_execute_unit
// Drives decoded instructions into the execute unit: a directed set covering
// every operation and the corner cases, then random programs with bursty
// idling on both channels. The checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_rv32_subset_execute_unit
  import rvx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HALF_PERIOD  = 5;
  localparam int          RESET_CYCLES = 2;
  localparam int          RANDOM_ITEMS = 1575;
  localparam int          QUIET_ITEMS  = 200;
  localparam int          HOLD_AT      = 400;
  localparam int          PAUSE_AT     = 800;
  localparam int          LONG_HOLD    = 150;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          IDLE_LIMIT   = 2000;
  localparam logic [3:0]  MODE_UNK_LO  = 4'd12;
  localparam logic [3:0]  MODE_UNK_HI  = 4'd15;
  localparam logic [4:0]  X0           = 5'd0;
  localparam logic [4:0]  REG_TOP      = 5'd31;
  localparam logic [29:0] TIDX_MAX     = '1;
  localparam logic [11:0] IMM_MAX      = 12'h7FF;
  localparam logic [11:0] IMM_MIN      = 12'h800;
  localparam logic [11:0] IMM_ONES     = 12'hFFF;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         mode;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg_a;
  logic [4:0]         src_reg_b;
  logic signed [11:0] immediate;
  logic [29:0]        target_index;
  logic               target_known;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        next_pc;
  logic               reg_written;
  logic [4:0]         write_index;
  logic signed [31:0] write_value;
  logic [1:0]         error_code;
  int                 fail_count;
  int                 outstanding;

  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;
  int stall_cycles  = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  rv32_subset_execute_unit dut (.*);

  rv32_exec_checker checker_i (.*);

  // Watchdog: end the run when neither channel moves a beat for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side back-pressure
  initial begin : result_pacer
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req && !held) begin
        // hold off long enough to fill the block and stall its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(99, 0) < 8) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(19, 1)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(40, 1)) @(posedge clk);
      end
    end
  end

  task automatic issue(logic [3:0] op, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                       logic [11:0] imm, logic [29:0] tidx, logic known);
    mode         <= op;
    dest_reg     <= rd;
    src_reg_a    <= ra;
    src_reg_b    <= rb;
    immediate    <= imm;
    target_index <= tidx;
    target_known <= known;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(99, 0) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
  endtask

  task automatic issue_random();
    logic [3:0]  op;
    logic [4:0]  rd, ra, rb;
    logic [11:0] imm;
    logic [29:0] tidx;
    logic        known;
    if ($urandom_range(99, 0) < 5)
      op = 4'($urandom_range(MODE_UNK_HI, MODE_UNK_LO));
    else
      op = 4'($urandom_range(OP_SRA, OP_ADD));
    rd  = 5'($urandom_range(REG_TOP, X0));
    ra  = 5'($urandom_range(REG_TOP, X0));
    rb  = 5'($urandom_range(REG_TOP, X0));
    imm = 12'($urandom());
    // equal operands so that bne also falls through
    if (op == OP_BNE && $urandom_range(99, 0) < 30)
      rb = ra;
    if ($urandom_range(99, 0) < 85)
      tidx = 30'($urandom_range(255, 0));
    else
      tidx = 30'($urandom());
    known = ($urandom_range(99, 0) < 85);
    issue(op, rd, ra, rb, imm, tidx, known);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int n;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    mode         <= OP_ADD;
    dest_reg     <= X0;
    src_reg_a    <= X0;
    src_reg_b    <= X0;
    immediate    <= '0;
    target_index <= '0;
    target_known <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // immediate extremes and wide values
    issue(OP_ADDI, 5'd1, X0, X0, IMM_MAX, '0, 1'b1);
    issue(OP_ADDI, 5'd2, X0, X0, IMM_MIN, '0, 1'b1);
    issue(OP_ADDI, 5'd3, X0, X0, IMM_ONES, '0, 1'b1);
    issue(OP_SRL, 5'd4, 5'd3, X0, 12'd1, '0, 1'b1);
    issue(OP_ADD, 5'd5, 5'd4, 5'd1, '0, '0, 1'b1);
    issue(OP_SUB, 5'd6, 5'd2, 5'd4, '0, '0, 1'b1);
    issue(OP_SLL, 5'd7, 5'd3, X0, 12'd31, '0, 1'b1);
    // shift amount comes from the low five bits only
    issue(OP_SRA, 5'd8, 5'd7, X0, IMM_ONES, '0, 1'b1);
    issue(OP_SRA, 5'd9, 5'd4, X0, '0, '0, 1'b1);
    issue(OP_SRL, 5'd10, 5'd7, X0, IMM_MIN, '0, 1'b1);
    issue(OP_AND, 5'd11, 5'd3, 5'd2, '0, '0, 1'b1);
    issue(OP_OR, 5'd12, 5'd1, 5'd2, '0, '0, 1'b1);
    issue(OP_XOR, 5'd13, 5'd3, 5'd4, '0, '0, 1'b1);
    // x0 discards its write and reads back zero
    issue(OP_ADD, X0, 5'd1, 5'd1, '0, '0, 1'b1);
    issue(OP_ADD, 5'd14, X0, 5'd1, '0, '0, 1'b1);
    issue(OP_BNE, 5'd15, 5'd1, 5'd2, '0, TIDX_MAX, 1'b1);
    issue(OP_BNE, 5'd15, 5'd1, 5'd2, '0, TIDX_MAX, 1'b0);
    issue(OP_BNE, 5'd15, 5'd1, 5'd1, '0, '0, 1'b0);
    issue(OP_JAL, 5'd15, X0, X0, '0, 30'd5, 1'b1);
    issue(OP_JAL, 5'd16, X0, X0, '0, TIDX_MAX, 1'b0);
    issue(OP_JALR, 5'd17, 5'd1, X0, '0, '0, 1'b1);
    issue(OP_JALR, X0, 5'd2, X0, IMM_MIN, '0, 1'b1);
    issue(OP_JALR, REG_TOP, 5'd3, X0, IMM_MAX, '0, 1'b1);
    issue(MODE_UNK_LO, REG_TOP, 5'd1, 5'd2, IMM_MAX, TIDX_MAX, 1'b1);
    issue(MODE_UNK_HI, REG_TOP, REG_TOP, REG_TOP, IMM_ONES, TIDX_MAX, 1'b0);
    issue(OP_XOR, 5'd30, REG_TOP, 5'd13, '0, '0, 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT)
        long_hold_req = 1'b1;
      if (n == PAUSE_AT) begin
        // hold the sender until every result is back
        in_valid <= 1'b0;
        wait_drained();
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS)
        quiet = 1'b1;
      issue_random();
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
